>>> design/itp_pkg.sv
// Shared types, constants and character tables for the infix-to-postfix converter.
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef logic [2:0] code_t;
    typedef logic [3:0] kind_t;
    typedef logic [1:0] prec_t;
    typedef logic [1:0] status_t;

    localparam code_t CODE_ADD  = 3'd0;
    localparam code_t CODE_SUB  = 3'd1;
    localparam code_t CODE_MUL  = 3'd2;
    localparam code_t CODE_BAR  = 3'd3;
    localparam code_t CODE_CARET = 3'd4;
    localparam code_t CODE_AMP  = 3'd5;
    localparam code_t CODE_HASH = 3'd6;
    localparam code_t CODE_OPEN = 3'd7;

    localparam kind_t KIND_OPEN  = 4'd7;
    localparam kind_t KIND_CLOSE = 4'd8;
    localparam kind_t KIND_OTHER = 4'd9;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_MISMATCH = 2'd1;
    localparam status_t ST_NO_OP    = 2'd2;
    localparam status_t ST_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        code_t code;
    } stack_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        code_t            top;
    } stack_stat_t;

    function automatic kind_t classify(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_ADD:   k = {1'b0, CODE_ADD};
            CH_SUB:   k = {1'b0, CODE_SUB};
            CH_MUL:   k = {1'b0, CODE_MUL};
            CH_BAR:   k = {1'b0, CODE_BAR};
            CH_CARET: k = {1'b0, CODE_CARET};
            CH_AMP:   k = {1'b0, CODE_AMP};
            CH_HASH:  k = {1'b0, CODE_HASH};
            CH_OPEN:  k = KIND_OPEN;
            CH_CLOSE: k = KIND_CLOSE;
            default:  k = KIND_OTHER;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] code_char(input code_t code);
        logic [7:0] c;
        case (code)
            CODE_ADD:   c = CH_ADD;
            CODE_SUB:   c = CH_SUB;
            CODE_MUL:   c = CH_MUL;
            CODE_BAR:   c = CH_BAR;
            CODE_CARET: c = CH_CARET;
            CODE_AMP:   c = CH_AMP;
            CODE_HASH:  c = CH_HASH;
            default:    c = CH_OPEN;
        endcase
        return c;
    endfunction

    function automatic prec_t code_prec(input code_t code);
        prec_t p;
        case (code)
            CODE_ADD, CODE_SUB: p = 2'd1;
            CODE_MUL:           p = 2'd2;
            CODE_OPEN:          p = 2'd0;
            default:            p = 2'd3;
        endcase
        return p;
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9) ||
               c == CH_DOT || c == CH_APOS;
    endfunction

endpackage

`default_nettype wire

>>> design/itp_op_stack.sv
// Operator stack: cached top entry, array for the rest, registered read of the entry below.
`default_nettype none

module itp_op_stack
    import itp_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  stack_cmd_t  cmd,
    output stack_stat_t stat
);

    logic [CNT_W-1:0]  count_reg, count_next;
    code_t             top_reg, top_next;
    code_t             below_reg;
    code_t             mem [STACK_DEPTH];
    logic [CNT_W-1:0]  wr_full, rd_full;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              wr_en, rd_en;

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
            top_next   = cmd.code;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            top_next   = below_reg;
        end
    end

    assign wr_full = count_reg - CNT_W'(1);
    assign wr_addr = wr_full[ADDR_W-1:0];
    assign wr_en   = cmd.push && !cmd.clear && (count_reg != '0);
    assign rd_full = count_next - CNT_W'(2);
    assign rd_addr = rd_full[ADDR_W-1:0];
    assign rd_en   = (count_next >= CNT_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                below_reg <= top_reg;
            end
            else
            begin
                below_reg <= mem[rd_addr];
            end
        end
    end

    assign stat.count = count_reg;
    assign stat.top   = top_reg;

endmodule

`default_nettype wire

>>> design/infix_to_postfix_converter_top.sv
// Infix-to-postfix converter top level: sequencer, status tracking and output register.
//
// Input channel (in_valid / in_stall, in_char, is_final): one expression
// character per transaction; is_final marks the last one.
// Output channel (out_valid / out_stall): each transaction is one postfix
// character (carries_char = 1) or, after the last character, one status
// transaction (carries_char = 0, end_of_expr = 1, status code).
// Timing: an accepted character is processed in the following cycle; a
// plain operand is then written to the output register. Each operator popped
// off the stack goes through the single stack port and is emitted in turn; a
// final flush pops every stacked entry, emitting operators and dropping open
// brackets, and then emits the status. in_stall is high from acceptance
// until the character's work is done.
// Stall: the output register holds a valid transaction while out_stall is high;
// the sequencer waits whenever it has a transaction to emit and that register is held.
// Reset: clears the stack, bracket balance and flags; nothing is emitted.
`default_nettype none

module infix_to_postfix_converter_top
    import itp_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [7:0] in_char,
    input  wire        is_final,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] out_char,
    output logic       carries_char,
    output logic       end_of_expr,
    output logic [1:0] status
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [7:0]  char_reg;
    logic        final_reg;
    kind_t       kind_reg;
    logic [15:0] balance_reg, balance_next;
    logic        saw_op_reg, saw_op_next;
    logic        ovf_reg, ovf_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        carries_reg, carries_next;
    logic        end_reg, end_next;
    status_t     status_reg, status_next;

    stack_cmd_t  cmd;
    stack_stat_t stat;

    logic        accept, can_emit, nonempty, full, top_open, pop_op;
    kind_t       in_kind;
    logic [1:0]  after_item;
    status_t     final_status;

    itp_op_stack u_stack (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .stat (stat)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign in_kind    = classify(in_char);
    assign can_emit   = !out_valid_reg || !out_stall;
    assign nonempty   = (stat.count != '0);
    assign full       = (stat.count == CNT_W'(STACK_DEPTH));
    assign top_open   = (stat.top == CODE_OPEN);
    assign pop_op     = nonempty && !top_open &&
                        (code_prec(stat.top) >= code_prec(kind_reg[2:0]));
    assign after_item = final_reg ? S_FLUSH : S_IDLE;

    always_comb
    begin
        if (balance_reg != '0)
        begin
            final_status = ST_MISMATCH;
        end
        else if (!saw_op_reg)
        begin
            final_status = ST_NO_OP;
        end
        else if (ovf_reg)
        begin
            final_status = ST_OVERFLOW;
        end
        else
        begin
            final_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        balance_next  = balance_reg;
        saw_op_next   = saw_op_reg;
        ovf_next      = ovf_reg;
        cmd           = '0;
        out_valid_next = out_valid_reg && out_stall;
        out_char_next = out_char_reg;
        carries_next  = carries_reg;
        end_next      = end_reg;
        status_next   = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_RUN;
                    saw_op_next = saw_op_reg || !is_operand(in_char);
                    if (in_kind == KIND_OPEN)
                    begin
                        balance_next = balance_reg + 16'd1;
                    end
                    else if (in_kind == KIND_CLOSE)
                    begin
                        balance_next = balance_reg - 16'd1;
                    end
                end
            end
            S_RUN:
            begin
                if (kind_reg == KIND_OTHER)
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = char_reg;
                        carries_next   = 1'b1;
                        end_next       = 1'b0;
                        status_next    = ST_OK;
                        state_next     = after_item;
                    end
                end
                else if (kind_reg == KIND_CLOSE)
                begin
                    if (!nonempty)
                    begin
                        state_next = after_item;
                    end
                    else if (top_open)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = after_item;
                    end
                    else if (can_emit)
                    begin
                        cmd.pop        = 1'b1;
                        out_valid_next = 1'b1;
                        out_char_next  = code_char(stat.top);
                        carries_next   = 1'b1;
                        end_next       = 1'b0;
                        status_next    = ST_OK;
                    end
                end
                else if (kind_reg != KIND_OPEN && pop_op)
                begin
                    if (can_emit)
                    begin
                        cmd.pop        = 1'b1;
                        out_valid_next = 1'b1;
                        out_char_next  = code_char(stat.top);
                        carries_next   = 1'b1;
                        end_next       = 1'b0;
                        status_next    = ST_OK;
                    end
                end
                else
                begin
                    // operator or open bracket: push, dropped when full
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        cmd.code = kind_reg[2:0];
                    end
                    state_next = after_item;
                end
            end
            S_FLUSH:
            begin
                if (nonempty)
                begin
                    if (top_open)
                    begin
                        cmd.pop = 1'b1;
                    end
                    else if (can_emit)
                    begin
                        cmd.pop        = 1'b1;
                        out_valid_next = 1'b1;
                        out_char_next  = code_char(stat.top);
                        carries_next   = 1'b1;
                        end_next       = 1'b0;
                        status_next    = ST_OK;
                    end
                end
                else if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = 8'd0;
                    carries_next   = 1'b0;
                    end_next       = 1'b1;
                    status_next    = final_status;
                    cmd.clear      = 1'b1;
                    balance_next   = '0;
                    saw_op_next    = 1'b0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            balance_reg   <= '0;
            saw_op_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            balance_reg   <= balance_next;
            saw_op_reg    <= saw_op_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= in_char;
            final_reg <= is_final;
            kind_reg  <= in_kind;
        end
        out_char_reg <= out_char_next;
        carries_reg  <= carries_next;
        end_reg      <= end_next;
        status_reg   <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign carries_char = carries_reg;
    assign end_of_expr  = end_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire
